>>> rtl/adnf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adnf_pkg: shared types and constants of the Art-Net DMX packet framer
// Payload structs, configuration fields, register indexes and header layout.
// ----------------------------------------------------------------------------
package adnf_pkg;

   localparam int unsigned UNIVERSE_BYTES    = 512;
   localparam int unsigned HEADER_BYTES      = 18;
   localparam int unsigned PIXEL_QUEUE_DEPTH = 4;

   localparam int unsigned FRAME_POS_W      = 18;
   localparam int unsigned UNI_IDX_W        = 9;
   localparam int unsigned UNI_OFF_W        = 10;
   localparam int unsigned SEQ_W            = 8;
   localparam int unsigned FRAME_PIXELS_W   = 16;
   localparam int unsigned UNIVERSE_W       = 15;
   localparam int unsigned HDR_CNT_W        = 5;
   localparam int unsigned CSR_INDEX_W      = 2;
   localparam int unsigned CSR_DATA_W       = 16;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLED       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_PIXELS  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNIVERSE_BASE = 2'd2;

   // header byte positions after the eight ID characters
   localparam logic [HDR_CNT_W-1:0] HDR_OP_HI    = 5'd8;
   localparam logic [HDR_CNT_W-1:0] HDR_OP_LO    = 5'd9;
   localparam logic [HDR_CNT_W-1:0] HDR_VER_HI   = 5'd10;
   localparam logic [HDR_CNT_W-1:0] HDR_VER_LO   = 5'd11;
   localparam logic [HDR_CNT_W-1:0] HDR_SEQUENCE = 5'd12;
   localparam logic [HDR_CNT_W-1:0] HDR_PHYSICAL = 5'd13;
   localparam logic [HDR_CNT_W-1:0] HDR_UNI_LO   = 5'd14;
   localparam logic [HDR_CNT_W-1:0] HDR_UNI_HI   = 5'd15;
   localparam logic [HDR_CNT_W-1:0] HDR_LEN_HI   = 5'd16;
   localparam logic [HDR_CNT_W-1:0] HDR_LEN_LO   = 5'd17;

   localparam logic [7:0] OPCODE_OUTPUT_LO = 8'h50;
   localparam logic [7:0] PROTOCOL_VERSION = 8'd14;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       packet_end;
      logic       last_result;
   } rsp_payload_type;

   typedef struct packed {
      logic                      enabled;
      logic [FRAME_PIXELS_W-1:0] frame_pixels;
      logic [UNIVERSE_W-1:0]     universe_base;
   } cfg_type;

   // "Art-Net" followed by NUL
   function automatic logic [7:0] id_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0: ch = 8'h41;
         3'd1: ch = 8'h72;
         3'd2: ch = 8'h74;
         3'd3: ch = 8'h2D;
         3'd4: ch = 8'h4E;
         3'd5: ch = 8'h65;
         3'd6: ch = 8'h74;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

>>> rtl/adnf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adnf_front: request intake and pixel queue
// Drops pixels while framing is off or the frame is empty, queues the rest.
// ----------------------------------------------------------------------------
module adnf_front #(
   parameter int unsigned DEPTH = adnf_pkg::PIXEL_QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  adnf_pkg::cfg_type        cfg,
   input  logic                     req_push,
   output logic                     req_full,
   input  adnf_pkg::req_payload_type req_data,
   output logic                     q_valid,
   output adnf_pkg::req_payload_type q_data,
   input  logic                     q_pop
);
   import adnf_pkg::*;

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   req_payload_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          accept;
   logic          keep;

   assign req_full = (count_ff == CW'(DEPTH));
   assign accept   = req_push && !req_full;
   // pixels that would make no packet bytes never enter the queue
   assign keep     = accept && cfg.enabled && (cfg.frame_pixels != '0);
   assign q_valid  = (count_ff != '0);
   assign q_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (keep) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (keep && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!keep && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (keep) begin
         mem_ff[wr_ptr_ff] <= req_data;
      end
   end

endmodule

>>> rtl/adnf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adnf_back: packet byte sequencer
// Walks header, payload and pad bytes of each pixel, one byte per cycle while the output buffer has room.
// ----------------------------------------------------------------------------
module adnf_back (
   input  logic                      clock,
   input  logic                      reset,
   input  adnf_pkg::cfg_type         cfg,
   input  logic                      q_valid,
   input  adnf_pkg::req_payload_type q_data,
   output logic                      q_pop,
   input  logic                      out_ready,
   output logic                      out_push,
   output adnf_pkg::rsp_payload_type out_data
);
   import adnf_pkg::*;

   localparam logic [1:0] PH_HDR  = 2'd0;
   localparam logic [1:0] PH_DATA = 2'd1;
   localparam logic [1:0] PH_PAD  = 2'd2;

   localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HEADER_BYTES - 1);
   localparam logic [UNI_OFF_W-1:0] UB_OFF   = UNI_OFF_W'(UNIVERSE_BYTES);
   localparam logic [FRAME_POS_W-1:0] UB_POS = FRAME_POS_W'(UNIVERSE_BYTES);

   logic                   cur_valid_ff, cur_valid_in;
   req_payload_type        px_ff, px_in;
   logic [1:0]             k_ff, k_in;
   logic [1:0]             phase_ff, phase_in;
   logic [HDR_CNT_W-1:0]   hdr_cnt_ff, hdr_cnt_in;
   logic [FRAME_POS_W-1:0] pos_ff, pos_in;
   logic [UNI_IDX_W-1:0]   idx_ff, idx_in;
   logic [UNI_OFF_W-1:0]   off_ff, off_in;
   logic [SEQ_W-1:0]       seq_ff, seq_in;

   logic [FRAME_POS_W-1:0] total;
   logic [FRAME_POS_W-1:0] pos_inc;
   logic [FRAME_POS_W-1:0] rem;
   logic [UNI_OFF_W-1:0]   off_inc;
   logic [UNI_OFF_W-1:0]   chunk;
   logic [UNI_OFF_W-1:0]   len;
   logic [UNIVERSE_W-1:0]  uni;
   logic [SEQ_W-1:0]       seq_inc;
   logic [7:0]             px_byte;
   logic [7:0]             hdr_byte;
   logic                   step;
   logic                   close;
   logic                   frame_end;
   logic                   need_pad;
   logic                   pixel_done;
   logic                   restart;
   logic                   load;

   assign total   = {2'b00, cfg.frame_pixels} + {1'b0, cfg.frame_pixels, 1'b0};
   assign step    = cur_valid_ff && out_ready;
   assign pos_inc = pos_ff + 1'b1;
   assign off_inc = off_ff + 1'b1;
   assign frame_end = (pos_inc >= total);
   assign close     = (off_inc >= UB_OFF) || frame_end;
   assign need_pad  = close && off_inc[0];
   assign seq_inc   = seq_ff + 1'b1;

   // header length field: bytes left in the frame, capped, rounded up to even
   assign rem   = total - pos_ff;
   assign chunk = (rem > UB_POS) ? UB_OFF : rem[UNI_OFF_W-1:0];
   assign len   = (chunk + 1'b1) & ~UNI_OFF_W'(1);
   assign uni   = cfg.universe_base + {{(UNIVERSE_W - UNI_IDX_W){1'b0}}, idx_ff};

   always_comb begin
      case (k_ff)
         2'd0:    px_byte = px_ff.red;
         2'd1:    px_byte = px_ff.green;
         default: px_byte = px_ff.blue;
      endcase
   end

   always_comb begin
      case (hdr_cnt_ff)
         HDR_OP_HI:    hdr_byte = 8'h00;
         HDR_OP_LO:    hdr_byte = OPCODE_OUTPUT_LO;
         HDR_VER_HI:   hdr_byte = 8'h00;
         HDR_VER_LO:   hdr_byte = PROTOCOL_VERSION;
         HDR_SEQUENCE: hdr_byte = seq_ff;
         HDR_PHYSICAL: hdr_byte = 8'h00;
         HDR_UNI_LO:   hdr_byte = uni[7:0];
         HDR_UNI_HI:   hdr_byte = {1'b0, uni[14:8]};
         HDR_LEN_HI:   hdr_byte = {6'b000000, len[9:8]};
         HDR_LEN_LO:   hdr_byte = len[7:0];
         default:      hdr_byte = id_char(hdr_cnt_ff[2:0]);
      endcase
   end

   assign pixel_done = step && (k_ff == 2'd2) &&
                       ((phase_ff == PH_PAD) || ((phase_ff == PH_DATA) && !need_pad));
   // a frame shrunk while idle restarts at byte zero when the next pixel comes
   assign restart = !cur_valid_ff && (pos_ff >= total);
   assign load    = q_valid && (!cur_valid_ff || pixel_done);
   assign q_pop   = load;

   always_comb begin
      cur_valid_in = cur_valid_ff;
      px_in        = px_ff;
      k_in         = k_ff;
      phase_in     = phase_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      off_in       = off_ff;
      seq_in       = seq_ff;
      out_push     = 1'b0;
      out_data     = '{data_byte: hdr_byte, packet_end: 1'b0, last_result: 1'b0};

      if (step) begin
         out_push = 1'b1;
         case (phase_ff)
            PH_HDR: begin
               if (hdr_cnt_ff == HDR_LAST) begin
                  hdr_cnt_in = '0;
                  phase_in   = PH_DATA;
               end else begin
                  hdr_cnt_in = hdr_cnt_ff + 1'b1;
               end
            end
            PH_DATA: begin
               out_data.data_byte   = px_byte;
               out_data.packet_end  = close && !need_pad;
               out_data.last_result = (k_ff == 2'd2) && !need_pad;
               off_in = close ? '0 : off_inc;
               pos_in = frame_end ? '0 : pos_inc;
               if (frame_end) begin
                  idx_in = '0;
                  seq_in = (seq_inc == '0) ? SEQ_W'(1) : seq_inc;
               end else if (close) begin
                  idx_in = idx_ff + 1'b1;
               end
               if (need_pad) begin
                  phase_in = PH_PAD;
               end else begin
                  phase_in     = close ? PH_HDR : PH_DATA;
                  k_in         = (k_ff == 2'd2) ? 2'd0 : k_ff + 1'b1;
                  cur_valid_in = (k_ff != 2'd2);
               end
            end
            PH_PAD: begin
               out_data.data_byte   = 8'h00;
               out_data.packet_end  = 1'b1;
               out_data.last_result = (k_ff == 2'd2);
               phase_in     = PH_HDR;
               k_in         = (k_ff == 2'd2) ? 2'd0 : k_ff + 1'b1;
               cur_valid_in = (k_ff != 2'd2);
            end
            default: begin
               out_push = 1'b0;
               phase_in = PH_HDR;
            end
         endcase
      end

      if (load) begin
         cur_valid_in = 1'b1;
         px_in        = q_data;
         if (!cur_valid_ff) begin
            k_in       = 2'd0;
            hdr_cnt_in = '0;
            phase_in   = (restart || (off_ff == '0)) ? PH_HDR : PH_DATA;
            if (restart) begin
               pos_in = '0;
               idx_in = '0;
               off_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         k_ff         <= '0;
         phase_ff     <= PH_HDR;
         hdr_cnt_ff   <= '0;
         pos_ff       <= '0;
         idx_ff       <= '0;
         off_ff       <= '0;
         seq_ff       <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         k_ff         <= k_in;
         phase_ff     <= phase_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         pos_ff       <= pos_in;
         idx_ff       <= idx_in;
         off_ff       <= off_in;
         seq_ff       <= seq_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff <= px_in;
   end

endmodule

>>> rtl/adnf_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adnf_out_queue: two-entry response buffer
// Decouples the byte sequencer from the response consumer.
// ----------------------------------------------------------------------------
module adnf_out_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_push,
   input  adnf_pkg::rsp_payload_type in_data,
   output logic                      in_ready,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output adnf_pkg::rsp_payload_type rsp_data
);
   import adnf_pkg::*;

   rsp_payload_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign in_ready  = (count_ff != 2'd2);
   assign rsp_empty = (count_ff == 2'd0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign do_push   = in_push && in_ready;
   assign do_pop    = rsp_pop && !rsp_empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

>>> rtl/artnet_dmx_packet_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// artnet_dmx_packet_framer: RGB pixels in, Art-Net OpOutput packet bytes out
// Frames pixels into 512-byte universes, each led by an 18-byte header.
// ----------------------------------------------------------------------------
// From an idle block, the first byte of a request passes the pixel queue, the
//   sequencer's pixel register and the response buffer before it shows.
// Throughput: one response byte per cycle from the sequencer while the response
//   buffer has room; a pixel gives three bytes, plus 18 header bytes per
//   universe, a pad byte per odd-length universe and a load after an idle spell.
// Reset (synchronous, active high) empties both queues, disables framing,
//   zeroes the configuration, the frame position and the sequence number.
// ----------------------------------------------------------------------------
module artnet_dmx_packet_framer #(
   parameter int unsigned PIXEL_QUEUE_DEPTH = adnf_pkg::PIXEL_QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request side: one RGB pixel per request
   input  logic                                 req_push,
   output logic                                 req_full,
   input  adnf_pkg::req_payload_type            req_data,
   // response side: one packet byte per response
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output adnf_pkg::rsp_payload_type            rsp_data,
   // register writes
   input  logic                                 csr_we,
   input  logic [adnf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [adnf_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import adnf_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   logic            q_valid;
   req_payload_type q_data;
   logic            q_pop;
   logic            out_push;
   logic            out_ready;
   rsp_payload_type out_data;

   // Register file. The user must write only while no request is in flight (the block does not enforce
   // this), so every queued pixel sees the settings that were live when it was accepted.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ENABLED:       cfg_in.enabled       = csr_wdata[0];
            CSR_FRAME_PIXELS:  cfg_in.frame_pixels  = csr_wdata[FRAME_PIXELS_W-1:0];
            CSR_UNIVERSE_BASE: cfg_in.universe_base = csr_wdata[UNIVERSE_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: takes requests, drops them while disabled or with an empty frame,
   // and queues the rest so intake runs ahead of byte generation.
   adnf_front #(
      .DEPTH (PIXEL_QUEUE_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_valid  (q_valid),
      .q_data   (q_data),
      .q_pop    (q_pop)
   );

   // Back: per pixel, three payload bytes, each preceded by a header when it
   // opens a universe, and a zero pad after an odd-length universe's last byte.
   adnf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .out_ready (out_ready),
      .out_push  (out_push),
      .out_data  (out_data)
   );

   // Response buffer: the sequencer keeps going while a byte waits to be taken.
   adnf_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .in_push   (out_push),
      .in_data   (out_data),
      .in_ready  (out_ready),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/adnf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adnf_checker: port-level checks for the packet framer
// Handshake stability, reset state and packet start after each packet end.
// ----------------------------------------------------------------------------
module adnf_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_full,
   input logic                      rsp_empty,
   input logic                      rsp_pop,
   input adnf_pkg::rsp_payload_type rsp_data
);
   import adnf_pkg::*;

   // set when the next response must be the first byte of a packet header
   logic hdr_next_ff, hdr_next_in;

   always_comb begin
      hdr_next_in = hdr_next_ff;
      if (rsp_pop && !rsp_empty) begin
         hdr_next_in = rsp_data.packet_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_next_ff <= 1'b1;
      end else begin
         hdr_next_ff <= hdr_next_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty)
      else $error("response withdrawn before pop");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> $stable(rsp_data))
      else $error("waiting response changed");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   a_packet_start: assert property (@(posedge clock) disable iff (reset)
      (hdr_next_ff && !rsp_empty) |-> (rsp_data.data_byte == id_char(3'd0)))
      else $error("packet does not open with the ID string");

endmodule

bind artnet_dmx_packet_framer adnf_checker u_adnf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);
